FILE: hw/rtl/gce_pkg.sv
package gce_pkg;

  // Width of the row field on the input channel.
  localparam int unsigned RowBitsW = 24;

  // Width of the window fields on the output channel.
  localparam int unsigned WinW = 9;

  // Configuration register indexes.
  localparam logic [2:0] CfgPosX      = 3'd0;
  localparam logic [2:0] CfgPosY      = 3'd1;
  localparam logic [2:0] CfgForeColor = 3'd2;
  localparam logic [2:0] CfgBackColor = 3'd3;
  localparam logic [2:0] CfgRotation  = 3'd4;

  // Rotation codes that move the address window.
  localparam logic [1:0] RotRowShift = 2'd2;
  localparam logic [1:0] RotColShift = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

FILE: hw/rtl/glyph_24x24_clipped_expander_unit.sv
// Glyph row expander with screen clipping.
//
// Each transfer on the input channel carries one glyph row (row_bits_i, bit
// GLYPH_SIZE-1 is the leftmost pixel). The block expands it into RGB565
// pixels, one output transfer per pixel, left to right. Pixels that fall
// left of column 0 or right of the screen are dropped, and a glyph that
// lies off the screen, or pos_x of zero, gives no pixels at all. Every
// pixel carries the glyph's address window; row_end_o marks the last pixel
// of a row and glyph_end_o the last pixel of the glyph's final row.
//
// Each row is captured into the per-row registers, and each pixel is then
// formed in the output register. One down counter walks over the row bits
// and selects one pixel per cycle while the output does not stall;
// in_stall_o stays high during that walk. A row that emits nothing leaves
// the block idle. A stall on the output channel holds the pixel register
// and pauses the walk.
//
// Configuration writes are accepted in every cycle. Position and rotation
// take effect for the next row and the colors for the next pixel formed.
// Reset clears the row counter and loads the register defaults.
module glyph_24x24_clipped_expander_unit #(
  parameter int unsigned SCREEN_WIDTH     = 240,
  parameter int unsigned SCREEN_HEIGHT    = 240,
  parameter int unsigned GLYPH_SIZE       = 24,
  parameter int unsigned CONTROLLER_LINES = 320
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [2:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [gce_pkg::RowBitsW-1:0]       row_bits_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [15:0]                        pixel_color_o,
  output logic                               row_end_o,
  output logic                               glyph_end_o,
  output logic [gce_pkg::WinW-1:0]           win_col_first_o,
  output logic [gce_pkg::WinW-1:0]           win_col_final_o,
  output logic [gce_pkg::WinW-1:0]           win_row_first_o,
  output logic [gce_pkg::WinW-1:0]           win_row_final_o
);

  import gce_pkg::*;

  // Column and row arithmetic width, wide enough for every bound compared.
  localparam int unsigned CW = $clog2(SCREEN_WIDTH + SCREEN_HEIGHT + GLYPH_SIZE + 512);
  // Bit index into the row and remaining pixel count.
  localparam int unsigned IW = $clog2(GLYPH_SIZE);
  localparam int unsigned NW = $clog2(GLYPH_SIZE + 1);
  // Row bits widened so that a glyph wider than the input field reads zeros.
  localparam int unsigned GW = (GLYPH_SIZE > RowBitsW) ? GLYPH_SIZE : RowBitsW;

  localparam logic [CW-1:0] GlyphC   = CW'(GLYPH_SIZE);
  localparam logic [CW-1:0] MaxPosX  = CW'(SCREEN_WIDTH + GLYPH_SIZE - 1);
  localparam logic [CW-1:0] ScrW     = CW'(SCREEN_WIDTH);
  localparam logic [CW-1:0] ScrH     = CW'(SCREEN_HEIGHT);
  localparam logic [IW-1:0] LastIdx  = IW'(GLYPH_SIZE - 1);
  localparam logic [IW-1:0] LastRow  = IW'(GLYPH_SIZE - 1);
  localparam logic [WinW-1:0] OffX   = WinW'(CONTROLLER_LINES - SCREEN_WIDTH);
  localparam logic [WinW-1:0] OffY   = WinW'(CONTROLLER_LINES - SCREEN_HEIGHT);
  localparam logic [WinW-1:0] GlyphM1W = WinW'(GLYPH_SIZE - 1);

  // Configuration registers.
  logic [8:0]  pos_x_q;
  logic [7:0]  pos_y_q;
  logic [15:0] fore_color_q;
  logic [15:0] back_color_q;
  logic [1:0]  rotation_q;

  // Sequencer and per-row registers.
  state_e          state_q, state_d;
  logic [IW-1:0]   row_idx_q;
  logic [GLYPH_SIZE-1:0] row_q;
  logic [IW-1:0]   bit_idx_q;
  logic [NW-1:0]   rem_q;
  logic            last_q;
  logic [WinW-1:0] wcf_q, wcl_q, wrf_q, wrl_q;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [15:0]     pix_q;
  logic            row_end_q, glyph_end_q;
  logic [WinW-1:0] o_wcf_q, o_wcl_q, o_wrf_q, o_wrl_q;

  logic            in_xfer;
  logic            load_pix;
  logic            item_off;
  logic [CW-1:0]   px, py, col0, col1, span;
  logic [NW-1:0]   cnt;
  logic [IW-1:0]   start_idx;
  logic            clip_left;
  logic [WinW-1:0] off_x, off_y;
  logic [GW-1:0]   row_ext;

  assign cfg_ready_o = 1'b1;

  // Row geometry, worked out once when a row is taken.
  always_comb begin
    px        = CW'(pos_x_q);
    py        = CW'(pos_y_q);
    item_off  = (px == '0) || (px > MaxPosX) || ((py + GlyphC) > ScrH);
    clip_left = (px < GlyphC);
    col0      = clip_left ? '0 : (px - GlyphC);
    start_idx = clip_left ? IW'(px - CW'(1)) : LastIdx;
    col1      = (px <= ScrW) ? (px - CW'(1)) : (ScrW - CW'(1));
    span      = col1 - col0 + CW'(1);
    cnt       = (span > GlyphC) ? NW'(GLYPH_SIZE) : NW'(span);
    off_x     = (rotation_q == RotColShift) ? OffX : '0;
    off_y     = (rotation_q == RotRowShift) ? OffY : '0;
    row_ext   = GW'(row_bits_i);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && !item_off) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load_pix && (rem_q == NW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    load_pix   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_RUN:  load_pix   = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_xfer = in_valid_i && !in_stall_o;

  always_comb begin
    if (load_pix) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q      <= 9'd24;
      pos_y_q      <= '0;
      fore_color_q <= 16'hFFFF;
      back_color_q <= '0;
      rotation_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPosX:      pos_x_q      <= cfg_data_i[8:0];
        CfgPosY:      pos_y_q      <= cfg_data_i[7:0];
        CfgForeColor: fore_color_q <= cfg_data_i;
        CfgBackColor: back_color_q <= cfg_data_i;
        CfgRotation:  rotation_q   <= cfg_data_i[1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_idx_q   <= '0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        // The row counter advances on every row, also one that emits nothing.
        row_idx_q <= (row_idx_q == LastRow) ? '0 : (row_idx_q + IW'(1));
        rem_q     <= item_off ? '0 : cnt;
      end else if (load_pix) begin
        rem_q <= rem_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      row_q     <= row_ext[GLYPH_SIZE-1:0];
      bit_idx_q <= start_idx;
      last_q    <= (row_idx_q == LastRow);
      wcf_q     <= WinW'(col0) + off_x;
      wcl_q     <= WinW'(col1) + off_x;
      wrf_q     <= WinW'(pos_y_q) + off_y;
      wrl_q     <= WinW'(pos_y_q) + GlyphM1W + off_y;
    end else if (load_pix) begin
      bit_idx_q <= bit_idx_q - IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pix) begin
      pix_q       <= row_q[bit_idx_q] ? fore_color_q : back_color_q;
      row_end_q   <= (rem_q == NW'(1));
      glyph_end_q <= (rem_q == NW'(1)) && last_q;
      o_wcf_q     <= wcf_q;
      o_wcl_q     <= wcl_q;
      o_wrf_q     <= wrf_q;
      o_wrl_q     <= wrl_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_color_o   = pix_q;
  assign row_end_o       = row_end_q;
  assign glyph_end_o     = glyph_end_q;
  assign win_col_first_o = o_wcf_q;
  assign win_col_final_o = o_wcl_q;
  assign win_row_first_o = o_wrf_q;
  assign win_row_final_o = o_wrl_q;

`ifndef NO_ASSERTIONS
  // A glyph end pixel always closes its row.
  a_glyph_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && glyph_end_o |-> row_end_o)
    else $error("glyph end without row end");

  // A pixel that does not close its row means the walk is still running.
  a_more_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_end_o |-> state_q == ST_RUN)
    else $error("row left unfinished");

  // The walk never runs with nothing left to emit.
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> rem_q != '0)
    else $error("running with empty count");

  // A row off the screen leaves the block ready in the next cycle.
  a_off_row_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && item_off |=> state_q == ST_IDLE)
    else $error("off-screen row started a walk");

  // The row counter stays within the glyph.
  a_row_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_idx_q <= LastRow)
    else $error("row counter out of range");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// Testbench for the glyph row expander.
//
// Rows of a 24x24 glyph go in on the input channel. For each row the block
// sends zero or more RGB565 pixels on the output channel, and each pixel
// carries the glyph's address window. The scoreboard keeps its own copy of
// the registers and of the row counter. For every row transfer it expands
// the row into the pixels it expects. Each pixel transfer is then compared,
// field by field, with the oldest pixel still waiting.
//
// Registers are only written while the block is idle. That is after reset,
// or once every expected pixel has arrived and a short settle time has
// passed, since rows that lie off screen give no pixels to wait for.
module testbench;
  import gce_pkg::*;

  // Geometry of the block as instantiated (its default parameters).
  localparam int unsigned ScreenW   = 240;
  localparam int unsigned ScreenH   = 240;
  localparam int unsigned GlyphSize = 24;
  localparam int unsigned CtrlLines = 320;

  // Highest index on the configuration port. Indexes above CfgRotation map
  // to no register, and the block has to ignore writes to them.
  localparam logic [2:0] CfgIdxTop = 3'd7;

  // A safe wait before the block counts as idle once no pixel is outstanding.
  localparam int unsigned SettleCycles = 30;
  // Length of the one long hold-off on the output side.
  localparam int unsigned LongHold = 400;
  // The random part stops once about this many rows have been sent.
  localparam int unsigned RandomRows = 140;
  // Watchdog limit, many times the length of the slowest legal run.
  localparam int unsigned Limit = 400000;

  typedef struct packed {
    logic [15:0]     color;
    logic            row_end;
    logic            glyph_end;
    logic [WinW-1:0] col_first;
    logic [WinW-1:0] col_final;
    logic [WinW-1:0] row_first;
    logic [WinW-1:0] row_final;
  } pixel_t;

  // One set of register values, as raw words on the write port. The upper
  // bits beyond each register's width are free and must be dropped.
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] fore;
    logic [15:0] back;
    logic [15:0] rot;
  } glyph_setting_t;

  // The scoreboard: a shadow of the registers and the row counter, plus the
  // queue of pixels that the rows accepted so far still owe.
  class glyph_pixel_board;
    logic [8:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [1:0]  rotation;
    logic [4:0]  row_count;
    pixel_t      pixel_q[$];
    int unsigned errors;

    function new();
      pos_x      = 9'd24;
      pos_y      = 8'd0;
      fore_color = 16'hFFFF;
      back_color = 16'h0000;
      rotation   = 2'd0;
      row_count  = 5'd0;
      errors     = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [15:0] data);
      case (index)
        CfgPosX:      pos_x = data[8:0];
        CfgPosY:      pos_y = data[7:0];
        CfgForeColor: fore_color = data;
        CfgBackColor: back_color = data;
        CfgRotation:  rotation = data[1:0];
        default: ;
      endcase
    endfunction

    // Expands one accepted row into the pixels the block must send for it.
    function void note_row(logic [RowBitsW-1:0] bits);
      logic                last_row;
      int unsigned         first_col;
      int unsigned         final_col;
      int unsigned         count;
      int unsigned         col_off;
      int unsigned         row_off;
      logic [RowBitsW-1:0] walk;
      pixel_t              px;
      last_row  = (row_count == GlyphSize - 1);
      // The counter moves on every row, also on rows that give no pixels.
      row_count = last_row ? 5'd0 : row_count + 5'd1;
      if (pos_x == 0 || pos_x > ScreenW + GlyphSize - 1 || pos_y + GlyphSize > ScreenH)
        return;
      if (pos_x >= GlyphSize) begin
        first_col = pos_x - GlyphSize;
        walk      = bits;
      end else begin
        // Left clip: the hidden left pixels are shifted out of the row.
        first_col = 0;
        walk      = bits << (GlyphSize - pos_x);
      end
      final_col = (pos_x <= ScreenW) ? pos_x - 1 : ScreenW - 1;
      count     = final_col - first_col + 1;
      if (count > GlyphSize) count = GlyphSize;
      col_off = (rotation == RotColShift) ? CtrlLines - ScreenW : 0;
      row_off = (rotation == RotRowShift) ? CtrlLines - ScreenH : 0;
      for (int unsigned k = 0; k < count; k++) begin
        px.color     = walk[GlyphSize-1] ? fore_color : back_color;
        px.row_end   = (k + 1 == count);
        px.glyph_end = px.row_end && last_row;
        px.col_first = WinW'(first_col + col_off);
        px.col_final = WinW'(final_col + col_off);
        px.row_first = WinW'(pos_y + row_off);
        px.row_final = WinW'(pos_y + GlyphSize - 1 + row_off);
        pixel_q.push_back(px);
        walk = walk << 1;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: pixel with none expected: color %h row_end %b glyph_end %b",
                   $realtime, got.color, got.row_end, got.glyph_end);
        return;
      end
      want = pixel_q.pop_front();
      if (got.color !== want.color || got.row_end !== want.row_end ||
          got.glyph_end !== want.glyph_end || got.col_first !== want.col_first ||
          got.col_final !== want.col_final || got.row_first !== want.row_first ||
          got.row_final !== want.row_final) begin
        errors++;
        if (errors <= 10)
          $display("%0t: pixel mismatch: expected %h %b %b col %0d..%0d row %0d..%0d, %s",
                   $realtime, want.color, want.row_end, want.glyph_end, want.col_first,
                   want.col_final, want.row_first, want.row_final,
                   $sformatf("got %h %b %b col %0d..%0d row %0d..%0d", got.color,
                             got.row_end, got.glyph_end, got.col_first, got.col_final,
                             got.row_first, got.row_final));
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i;
  logic [15:0]         cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [RowBitsW-1:0] row_bits_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [15:0]         pixel_color_o;
  logic                row_end_o;
  logic                glyph_end_o;
  logic [WinW-1:0]     win_col_first_o;
  logic [WinW-1:0]     win_col_final_o;
  logic [WinW-1:0]     win_row_first_o;
  logic [WinW-1:0]     win_row_final_o;

  glyph_pixel_board board;
  pixel_t           seen_px;
  logic             quiet;         // When set, neither side idles.
  logic             hold_trigger;  // Starts the long hold-off.
  logic             hold_active;
  int unsigned      rx_wait;
  int unsigned      rx_draw;
  int unsigned      cycle_count;

  glyph_24x24_clipped_expander_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .row_bits_i      (row_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_color_o   (pixel_color_o),
    .row_end_o       (row_end_o),
    .glyph_end_o     (glyph_end_o),
    .win_col_first_o (win_col_first_o),
    .win_col_final_o (win_col_final_o),
    .win_row_first_o (win_row_first_o),
    .win_row_final_o (win_row_final_o)
  );

  assign seen_px = {pixel_color_o, row_end_o, glyph_end_o, win_col_first_o,
                    win_col_final_o, win_row_first_o, win_row_final_o};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run ends here if the block stops making progress.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == Limit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Pixel receiver. Every transfer is checked at the edge where it happens;
  // the values read here are the ones from before that edge. After each
  // transfer the receiver, unless quiet, draws a random stall, possibly none,
  // and the long hold-off overrides everything while it lasts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait     <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) board.check_pixel(seen_px);
      if (hold_active) begin
        out_stall_i <= 1'b1;
      end else if (rx_wait != 0) begin
        out_stall_i <= 1'b1;
        rx_wait     <= rx_wait - 1;
      end else if (out_valid_o && !out_stall_i && !quiet) begin
        rx_draw = $urandom_range(0, 7);
        out_stall_i <= (rx_draw != 0);
        rx_wait     <= (rx_draw != 0) ? rx_draw - 1 : 0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // The long hold-off runs in its own process so that the sender keeps
  // offering rows meanwhile. The block then fills up and stalls its input.
  initial begin : long_hold
    hold_active <= 1'b0;
    wait (hold_trigger);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  // One register write; the shadow copy changes at the accepting edge.
  // Valid stays high so that writes can follow each other back to back.
  task automatic cfg_write(input logic [2:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(index, data);
  endtask

  // Writes all five registers, then some writes to unmapped indexes.
  task automatic apply_setting(input glyph_setting_t s, input int unsigned junk_writes);
    cfg_write(CfgPosX, s.pos_x);
    cfg_write(CfgPosY, s.pos_y);
    cfg_write(CfgForeColor, s.fore);
    cfg_write(CfgBackColor, s.back);
    cfg_write(CfgRotation, s.rot);
    for (int unsigned j = 0; j < junk_writes; j++)
      cfg_write(3'(CfgRotation + 1 + (j % (CfgIdxTop - CfgRotation))), 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one row after a random gap and waits for its transfer. With no
  // gap, valid simply stays high from the previous row.
  task automatic send_row(input logic [RowBitsW-1:0] bits);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_bits_i <= bits;
    do @(posedge clk_i); while (in_stall_o);
    board.note_row(bits);
  endtask

  // Ends a group of rows: waits for every owed pixel, then lets the block
  // finish any row that gives no pixels before registers change again.
  task automatic finish_rows();
    in_valid_i <= 1'b0;
    while (board.pixel_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random register values, mostly with the glyph on screen. Edge positions
  // and off-screen positions show up now and then. When on_screen is set,
  // the glyph is placed fully inside the screen.
  function automatic glyph_setting_t draw_setting(input bit on_screen);
    glyph_setting_t s;
    int unsigned    x;
    int unsigned    y;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: x = 1;
          1: x = GlyphSize - 1;
          2: x = GlyphSize;
          3: x = ScreenW;
          4: x = ScreenW + 1;
          default: x = ScreenW + GlyphSize - 1;
        endcase
      end
      1: x = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(ScreenW + GlyphSize, 511);
      default: x = $urandom_range(1, ScreenW + GlyphSize - 1);
    endcase
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(ScreenH - GlyphSize + 1, 255)
                                     : $urandom_range(0, ScreenH - GlyphSize);
    if (on_screen) begin
      x = $urandom_range(GlyphSize, ScreenW);
      y = $urandom_range(0, ScreenH - GlyphSize);
    end
    // The bits above each register's width are random and must be dropped.
    s.pos_x = {7'($urandom), 9'(x)};
    s.pos_y = {8'($urandom), 8'(y)};
    s.fore  = 16'($urandom);
    s.back  = 16'($urandom);
    s.rot   = {14'($urandom), 2'($urandom_range(0, 3))};
    return s;
  endfunction

  initial begin : stimulus
    glyph_setting_t      edge_cases[9];
    logic [RowBitsW-1:0] first_rows[4];
    glyph_setting_t      s;
    int unsigned         random_rows;
    int unsigned         phase;
    int unsigned         n;

    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CfgPosX;
    cfg_data_i   <= 16'h0000;
    in_valid_i   <= 1'b0;
    row_bits_i   <= '0;
    quiet        <= 1'b0;
    hold_trigger = 1'b0;
    board        = new();

    // Clip and placement cases: one pixel at the left edge, left clip at the
    // bottom, the right screen edge exactly, right clip, one pixel at the
    // far right, zero position, off screen to the right, off screen below,
    // and all ones in the positions. Upper bits of some words are set on purpose.
    edge_cases[0] = '{16'h0001, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
    edge_cases[1] = '{16'h0017, 16'hFFD8, 16'h0000, 16'hFFFF, 16'h0001};
    edge_cases[2] = '{16'h00F0, 16'h0064, 16'hF800, 16'h07E0, 16'h0002};
    edge_cases[3] = '{16'h00F1, 16'h00D8, 16'h001F, 16'hFFE0, 16'h0003};
    edge_cases[4] = '{16'hFF07, 16'h0000, 16'h1234, 16'h4321, 16'hFFFF};
    edge_cases[5] = '{16'h0000, 16'h0000, 16'h1234, 16'h4321, 16'h0000};
    edge_cases[6] = '{16'h0108, 16'h000A, 16'hAAAA, 16'h5555, 16'h0003};
    edge_cases[7] = '{16'h0064, 16'h00D9, 16'h5555, 16'hAAAA, 16'h0002};
    edge_cases[8] = '{16'hFFFF, 16'h00FF, 16'hA5A5, 16'h5A5A, 16'h0001};
    first_rows    = '{24'h000000, 24'hFFFFFF, 24'h800001, 24'hAAAAAA};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first rows run with the register defaults.
    foreach (first_rows[i]) send_row(first_rows[i]);
    finish_rows();
    foreach (edge_cases[i]) begin
      // The screen-edge case also gets a write to every unmapped index, and
      // its rows then show that none of them changed a register.
      apply_setting(edge_cases[i], (i == 2) ? CfgIdxTop - CfgRotation : 0);
      send_row(24'h800001);
      send_row(24'h7FFFFE);
      finish_rows();
    end

    // Random part: groups of rows under random settings. Groups are long
    // enough that the row counter wraps on screen and marks glyph ends.
    random_rows = 0;
    phase       = 0;
    while (random_rows < RandomRows) begin
      s = draw_setting(phase == 2);
      quiet <= (phase == 2) ? 1'b0 : ($urandom_range(0, 3) == 0);
      apply_setting(s, $urandom_range(0, 1));
      n = (phase == 2) ? GlyphSize : $urandom_range(4, GlyphSize);
      // In the third group the receiver holds off for a long stretch.
      if (phase == 2) hold_trigger = 1'b1;
      repeat (n) send_row(24'($urandom));
      finish_rows();
      random_rows += n;
      phase++;
    end

    if (board.errors == 0 && board.pixel_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
